@@ rtl/ir_pulse_distance_decoder_core_macros.svh @@
// ----------------------------------------------------------------------------
// IR pulse-distance decoder assertion macros
// Concurrent assertion wrappers, empty when synthesised.
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_DISTANCE_DECODER_CORE_MACROS_SVH
`define IR_PULSE_DISTANCE_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset
`define IPDD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset
`define IPDD_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define IPDD_ASSERT(lbl, clk, rst_n, prop, msg)

`define IPDD_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

@@ rtl/ipdd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse-distance decoder package
// Shared widths, register indexes, reset values and the command item type.
// ----------------------------------------------------------------------------
package ipdd_pkg;

    // Port and field widths
    localparam int TIME_W     = 32;
    localparam int GAP_W      = 24;
    localparam int GLITCH_W   = 16;
    localparam int HDR_W      = 5;
    localparam int CURSOR_W   = 6;
    localparam int CODE_W     = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    // Header skip saturates here
    localparam logic [HDR_W-1:0] HDR_MAX = 5'd16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESTART_GAP  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MIN   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH_LIMIT = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BITS  = 4'd3;

    // Configuration reset values
    localparam logic [GAP_W-1:0]    RST_RESTART_GAP  = 24'd20000;
    localparam logic [GAP_W-1:0]    RST_LEADER_MIN   = 24'd12000;
    localparam logic [GLITCH_W-1:0] RST_GLITCH_LIMIT = 16'd1000;
    localparam logic [HDR_W-1:0]    RST_HEADER_BITS  = 5'd0;

    // Divide by 1000 for spans below 2^24: q = (x * ceil(2^34/1000)) >> 34
    localparam int               RECIP_W     = 25;
    localparam logic [RECIP_W-1:0] DIV1000_RECIP = 25'd17179870;
    localparam int               RECIP_SHIFT = 34;
    localparam int               PROD_W      = GAP_W + RECIP_W;
    localparam int               QUOT_W      = PROD_W - RECIP_SHIFT;

    // Command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_BIT,
        CMD_EMIT
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [GAP_W-1:0] span;   // interval plus carried glitch time
        logic [2:0]       pos;    // bit position within the byte
        logic [2:0]       idx;    // byte number, four and up is discarded
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_beat;

endpackage

@@ rtl/ipdd_queue.sv @@
`timescale 1ns / 1ps
`include "ir_pulse_distance_decoder_core_macros.svh"
// ----------------------------------------------------------------------------
// IR pulse-distance decoder command queue
// Small FIFO of commands between the edge classifier and the data back end.
// ----------------------------------------------------------------------------
module ipdd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ipdd_pkg::t_cmd_beat i_push,
    output logic               o_full,
    output ipdd_pkg::t_cmd_beat o_head,
    input  logic               i_pop
);
    import ipdd_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;
    logic              push;
    logic              pop;

    assign push = i_push.valid;
    assign pop  = i_pop;

    assign o_full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    `IPDD_ASSERT_NEVER(a_no_push_full, i_clk, i_rst_n, push && o_full, "push into full queue")
    `IPDD_ASSERT_NEVER(a_no_pop_empty, i_clk, i_rst_n, pop && !o_head.valid, "pop from empty queue")
    `IPDD_ASSERT(a_push_lands, i_clk, i_rst_n, (push && !pop |=> r_count != '0), "push lost")

endmodule

@@ rtl/ipdd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse-distance decoder front end
// Holds configuration, measures edge intervals and turns accepted edges into
// clear, bit or emit commands for the back end.
// ----------------------------------------------------------------------------
module ipdd_front #(
    parameter int DATA_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ipdd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ipdd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [ipdd_pkg::TIME_W-1:0]     i_edge_time_us,
    output ipdd_pkg::t_cmd_beat             o_push,
    input  logic                            i_queue_full
);
    import ipdd_pkg::*;

    logic [GAP_W-1:0]    r_restart_gap;
    logic [GAP_W-1:0]    r_leader_min;
    logic [GLITCH_W-1:0] r_glitch_limit;
    logic [HDR_W-1:0]    r_header_bits;

    logic [TIME_W-1:0]   r_prev_time;
    logic [GLITCH_W-1:0] r_glitch_carry;
    logic                r_collecting;
    logic [CURSOR_W-1:0] r_bit_cursor;
    logic [TIME_W-1:0]   n_prev_time;
    logic [GLITCH_W-1:0] n_glitch_carry;
    logic                n_collecting;
    logic [CURSOR_W-1:0] n_bit_cursor;

    logic                accept;
    logic [TIME_W-1:0]   interval;
    logic [TIME_W:0]     span;
    logic                restart;
    logic                glitch;
    logic [HDR_W-1:0]    hdr;
    logic [CURSOR_W-1:0] last_cursor;
    logic [CURSOR_W-1:0] data_idx;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_queue_full;
    assign accept      = i_in_valid && !i_queue_full;

    assign interval    = i_edge_time_us - r_prev_time;
    assign span        = {1'b0, interval} + (TIME_W + 1)'(r_glitch_carry);
    assign restart     = (span >= (TIME_W + 1)'(r_restart_gap));
    assign glitch      = (span < (TIME_W + 1)'(r_glitch_limit));
    assign hdr         = (r_header_bits > HDR_MAX) ? HDR_MAX : r_header_bits;
    assign last_cursor = CURSOR_W'(DATA_BITS) + CURSOR_W'(hdr);
    assign data_idx    = r_bit_cursor - CURSOR_W'(hdr);

    always_comb begin
        n_prev_time    = r_prev_time;
        n_glitch_carry = r_glitch_carry;
        n_collecting   = r_collecting;
        n_bit_cursor   = r_bit_cursor;
        o_push.valid    = 1'b0;
        o_push.cmd.kind = CMD_BIT;
        o_push.cmd.span = span[GAP_W-1:0];
        o_push.cmd.pos  = data_idx[2:0];
        o_push.cmd.idx  = data_idx[5:3];
        if (accept) begin
            n_prev_time = i_edge_time_us;
            if (restart) begin
                n_collecting = 1'b0;
            end else if (glitch) begin
                // carry the whole span into the next interval
                n_glitch_carry = span[GLITCH_W-1:0];
            end else begin
                n_glitch_carry = '0;
                if (!r_collecting) begin
                    if (span >= (TIME_W + 1)'(r_leader_min)) begin
                        o_push.valid    = 1'b1;
                        o_push.cmd.kind = CMD_CLEAR;
                        n_collecting    = 1'b1;
                        n_bit_cursor    = '0;
                    end
                end else if (r_bit_cursor > last_cursor) begin
                    o_push.valid    = 1'b1;
                    o_push.cmd.kind = CMD_EMIT;
                end else if (r_bit_cursor < CURSOR_W'(hdr)) begin
                    // skip header edge
                    n_bit_cursor = r_bit_cursor + 1'b1;
                end else begin
                    o_push.valid    = 1'b1;
                    o_push.cmd.kind = CMD_BIT;
                    n_bit_cursor    = r_bit_cursor + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time    <= '0;
            r_glitch_carry <= '0;
            r_collecting   <= 1'b0;
            r_bit_cursor   <= '0;
        end else begin
            r_prev_time    <= n_prev_time;
            r_glitch_carry <= n_glitch_carry;
            r_collecting   <= n_collecting;
            r_bit_cursor   <= n_bit_cursor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restart_gap  <= RST_RESTART_GAP;
            r_leader_min   <= RST_LEADER_MIN;
            r_glitch_limit <= RST_GLITCH_LIMIT;
            r_header_bits  <= RST_HEADER_BITS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RESTART_GAP:  r_restart_gap  <= i_cfg_data[GAP_W-1:0];
                CFG_LEADER_MIN:   r_leader_min   <= i_cfg_data[GAP_W-1:0];
                CFG_GLITCH_LIMIT: r_glitch_limit <= i_cfg_data[GLITCH_W-1:0];
                CFG_HEADER_BITS:  r_header_bits  <= i_cfg_data[HDR_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

@@ rtl/ipdd_back.sv @@
`timescale 1ns / 1ps
`include "ir_pulse_distance_decoder_core_macros.svh"
// ----------------------------------------------------------------------------
// IR pulse-distance decoder back end
// Divides bit spans by 1000, packs bits into the code bytes and registers
// emitted codes on the output channel.
// ----------------------------------------------------------------------------
module ipdd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ipdd_pkg::t_cmd_beat         i_head,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ipdd_pkg::CODE_W-1:0] o_ir_code
);
    import ipdd_pkg::*;

    logic              r_a_valid;
    t_cmd              r_a_cmd;
    logic [PROD_W-1:0] r_prod;
    logic [7:0]        r_accum;
    logic [CODE_W-1:0] r_code;
    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_code;

    logic              a_adv;
    logic              a_emit;
    logic [QUOT_W-1:0] quot;
    logic [7:0]        bit_val;
    logic [7:0]        shifted;
    logic [7:0]        accum_or;

    assign a_emit = (r_a_cmd.kind == CMD_EMIT);
    // an emit waits for the output register, everything else retires at once
    assign a_adv  = r_a_valid && (!a_emit || !r_out_valid || !i_out_stall);
    assign o_pop  = i_head.valid && (!r_a_valid || a_adv);

    assign quot     = r_prod[PROD_W-1:RECIP_SHIFT];
    assign bit_val  = quot[7:0] - 8'd1;
    assign shifted  = bit_val << (3'd7 - r_a_cmd.pos);
    assign accum_or = r_accum | shifted;

    assign o_out_valid = r_out_valid;
    assign o_ir_code   = r_out_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_accum     <= '0;
            r_code      <= '0;
        end else begin
            if (o_pop) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end

            if (a_adv && a_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (a_adv) begin
                case (r_a_cmd.kind)
                    CMD_CLEAR: begin
                        r_accum <= '0;
                        r_code  <= '0;
                    end
                    CMD_BIT: begin
                        if (r_a_cmd.pos == 3'd7) begin
                            r_accum <= '0;
                            // first byte received lands in the top byte
                            case (r_a_cmd.idx)
                                3'd0:    r_code[31:24] <= accum_or;
                                3'd1:    r_code[23:16] <= accum_or;
                                3'd2:    r_code[15:8]  <= accum_or;
                                3'd3:    r_code[7:0]   <= accum_or;
                                default: begin
                                end
                            endcase
                        end else begin
                            r_accum <= accum_or;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_cmd <= i_head.cmd;
            r_prod  <= PROD_W'(i_head.cmd.span) * PROD_W'(DIV1000_RECIP);
        end
        if (a_adv && a_emit) begin
            r_out_code <= r_code;
        end
    end

    `IPDD_ASSERT(a_stage_held, i_clk, i_rst_n, (r_a_valid && !a_adv |=> r_a_valid), "stage dropped")
    `IPDD_ASSERT(a_out_from_emit, i_clk, i_rst_n, ($rose(r_out_valid) |-> $past(a_adv && a_emit)), "result without emit")
    `IPDD_ASSERT(a_clear_done, i_clk, i_rst_n, (a_adv && r_a_cmd.kind == CMD_CLEAR |=> r_accum == '0 && r_code == '0), "clear missed")

endmodule

@@ rtl/ir_pulse_distance_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse-distance decoder core
// Decodes NEC style remote frames from timestamped falling edges.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------
//  in       | input     | i_in_valid / o_in_stall | i_edge_time_us
//  out      | output    | o_out_valid/ i_out_stall| o_ir_code
//  cfg      | input     | i_cfg_valid/ o_cfg_ready| i_cfg_index, i_cfg_data
//
//  One edge is taken every cycle while the queue is not full, and the
//  front end classifies it in that cycle. A code passes the queue slot,
//  the back end command register with its divide-by-1000 product, then
//  the output register. A stalled output holds an emit command in the
//  back end and the commands behind it wait; the four-entry queue stalls
//  the input once it fills. Reset is synchronous, active low, and
//  restores the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module ir_pulse_distance_decoder_core #(
    parameter int DATA_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ipdd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ipdd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [ipdd_pkg::TIME_W-1:0]     i_edge_time_us,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [ipdd_pkg::CODE_W-1:0]     o_ir_code
);
    import ipdd_pkg::*;

    t_cmd_beat push;
    t_cmd_beat head;
    logic      queue_full;
    logic      pop;

    ipdd_front #(
        .DATA_BITS (DATA_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_edge_time_us (i_edge_time_us),
        .o_push         (push),
        .i_queue_full   (queue_full)
    );

    ipdd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (queue_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    ipdd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_ir_code   (o_ir_code)
    );

endmodule
